FILE: hw/rtl/aec_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aec_pkg
// Shared types and constants for the stereo audio error concealment core.
// ---------------------------------------------------------------------------
package aec_pkg;

    // Sample and statistics widths fixed by the stream format
    localparam int SAMPLE_WIDTH        = 16;
    localparam int COUNT_WIDTH_DEFAULT = 32;
    localparam int TOTAL_WIDTH         = 32;

    // Stream bus widths: fields packed from bit 0, padded to whole bytes
    localparam int S_FIELD_BITS  = 2 * SAMPLE_WIDTH + 2;
    localparam int S_TDATA_WIDTH = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS  = 2 * SAMPLE_WIDTH + 4 + 3 * TOTAL_WIDTH;
    localparam int M_TDATA_WIDTH = ((M_FIELD_BITS + 7) / 8) * 8;

    // Channel index within a pair
    localparam int CH_LEFT  = 0;
    localparam int CH_RIGHT = 1;

    // One mono sample with its error flag
    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] value;
        logic                    err;
    } aec_smp_t;

    // Stereo pair, element 0 is left
    typedef aec_smp_t [1:0] aec_pair_t;

    // Per-channel correction result and statistics strobes
    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] value;
        logic                    err;
        logic                    con;
        logic                    is_valid;
        logic                    is_conc;
        logic                    is_sil;
    } aec_chan_res_t;

    // How many original pairs the three-tap window holds
    typedef enum logic [1:0] {
        FILL_EMPTY = 2'd0,
        FILL_ONE   = 2'd1,
        FILL_FULL  = 2'd2
    } aec_fill_t;

endpackage

FILE: hw/rtl/audio_error_concealment_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// audio_error_concealment_core
// Stereo sample error concealment with one pair of delay.
// ---------------------------------------------------------------------------
// Each input item is a stereo pair with per-sample error flags; each pair
// comes out one item later. A flagged sample whose original neighbors are
// both clean is replaced by their average (truncated toward zero) and marked
// concealed; with a flagged neighbor it is zeroed and keeps its error mark.
// The first pair after reset or flush, and the pair pushed out by a flush
// (tuser = 1), leave uncorrected and uncounted. A flush with nothing held,
// and the first pair after reset or flush, produce no output item. The
// three-tap window registers feed the correction logic directly into a
// single output register, so an item is accepted in every cycle the output
// register is empty or being drained.
// ---------------------------------------------------------------------------
module audio_error_concealment_core
#(
    parameter int COUNT_WIDTH = aec_pkg::COUNT_WIDTH_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] left_sample, [31:16] right_sample, [32] left_error,
    // [33] right_error, rest zero
    input  logic [aec_pkg::S_TDATA_WIDTH-1:0] s_axis_tdata,
    // [0] flush
    input  logic                              s_axis_tuser,
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] out_left, [31:16] out_right, [32] out_left_error,
    // [33] out_right_error, [34] out_left_concealed, [35] out_right_concealed,
    // [67:36] valid_total, [99:68] concealed_total, [131:100] silenced_total,
    // rest zero
    output logic [aec_pkg::M_TDATA_WIDTH-1:0] m_axis_tdata
);
    import aec_pkg::*;

    localparam int PAD_BITS = M_TDATA_WIDTH - M_FIELD_BITS;

    aec_pair_t                  before_reg;
    aec_pair_t                  held_reg;
    aec_fill_t                  fill_reg;
    aec_fill_t                  fill_next;
    logic                       m_valid_reg;
    logic [M_TDATA_WIDTH-1:0]   m_data_reg;

    aec_pair_t                  in_pair;
    logic                       s_fire;
    logic                       flush;
    logic                       emit;
    logic                       fix;
    aec_chan_res_t [1:0]        chan_res;
    logic [1:0]                 inc_valid;
    logic [1:0]                 inc_conc;
    logic [1:0]                 inc_sil;
    logic [TOTAL_WIDTH-1:0]     valid_total;
    logic [TOTAL_WIDTH-1:0]     concealed_total;
    logic [TOTAL_WIDTH-1:0]     silenced_total;
    logic [M_TDATA_WIDTH-1:0]   m_data_next;

    // Unpack the input item
    assign in_pair[CH_LEFT].value  = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign in_pair[CH_RIGHT].value = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    assign in_pair[CH_LEFT].err    = s_axis_tdata[2*SAMPLE_WIDTH];
    assign in_pair[CH_RIGHT].err   = s_axis_tdata[2*SAMPLE_WIDTH+1];
    assign flush                   = s_axis_tuser;

    // Handshake: take an item whenever the output register can be refilled
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign emit          = s_fire && (fill_reg != FILL_EMPTY);
    assign fix           = !flush && (fill_reg == FILL_FULL);

    // Per-channel correction
    genvar ch;
    generate
        for (ch = 0; ch < 2; ch++)
        begin : g_chan
            aec_channel u_chan
            (
                .prev (before_reg[ch]),
                .cur  (held_reg[ch]),
                .nxt  (in_pair[ch]),
                .fix  (fix),
                .res  (chan_res[ch])
            );
        end
    endgenerate

    assign inc_valid = {1'b0, chan_res[CH_LEFT].is_valid} + {1'b0, chan_res[CH_RIGHT].is_valid};
    assign inc_conc  = {1'b0, chan_res[CH_LEFT].is_conc}  + {1'b0, chan_res[CH_RIGHT].is_conc};
    assign inc_sil   = {1'b0, chan_res[CH_LEFT].is_sil}   + {1'b0, chan_res[CH_RIGHT].is_sil};

    // Statistics
    aec_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_cnt_valid
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (emit),
        .inc   (inc_valid),
        .total (valid_total)
    );

    aec_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_cnt_conc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (emit),
        .inc   (inc_conc),
        .total (concealed_total)
    );

    aec_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_cnt_sil
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (emit),
        .inc   (inc_sil),
        .total (silenced_total)
    );

    // Pack the result item
    assign m_data_next = {{PAD_BITS{1'b0}},
                          silenced_total, concealed_total, valid_total,
                          chan_res[CH_RIGHT].con, chan_res[CH_LEFT].con,
                          chan_res[CH_RIGHT].err, chan_res[CH_LEFT].err,
                          chan_res[CH_RIGHT].value, chan_res[CH_LEFT].value};

    // Window occupancy
    always_comb
    begin
        fill_next = fill_reg;
        if (s_fire)
        begin
            if (flush)
            begin
                fill_next = FILL_EMPTY;
            end
            else if (fill_reg == FILL_EMPTY)
            begin
                fill_next = FILL_ONE;
            end
            else
            begin
                fill_next = FILL_FULL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= FILL_EMPTY;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Window shift and output data
    always_ff @(posedge clk)
    begin
        if (s_fire && !flush)
        begin
            before_reg <= held_reg;
            held_reg   <= in_pair;
        end
        if (emit)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Checks
    a_empty_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && fill_reg == FILL_EMPTY) |=> !m_valid_reg)
        else $error("result produced from an empty window");

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && flush) |=> (fill_reg == FILL_EMPTY))
        else $error("flush did not empty the window");

    a_window_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && !flush && fill_reg != FILL_EMPTY) |=> (fill_reg == FILL_FULL))
        else $error("window not full after second pair");

    a_conceal_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(m_data_reg[2*SAMPLE_WIDTH] && m_data_reg[2*SAMPLE_WIDTH+2])
                     && !(m_data_reg[2*SAMPLE_WIDTH+1] && m_data_reg[2*SAMPLE_WIDTH+3]))
        else $error("sample marked both concealed and in error");

endmodule

FILE: hw/rtl/aec_channel.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aec_channel
// Single-channel correction over a three-sample window of original samples.
// ---------------------------------------------------------------------------
module aec_channel
(
    input  aec_pkg::aec_smp_t      prev,
    input  aec_pkg::aec_smp_t      cur,
    input  aec_pkg::aec_smp_t      nxt,
    input  logic                   fix,   // 0 = pass cur through unchanged
    output aec_pkg::aec_chan_res_t res
);
    import aec_pkg::*;

    logic signed [SAMPLE_WIDTH:0]   sum;
    logic signed [SAMPLE_WIDTH:0]   sum_adj;
    logic signed [SAMPLE_WIDTH:0]   avg;

    // Neighbor average, truncated toward zero
    assign sum     = $signed({prev.value[SAMPLE_WIDTH-1], prev.value})
                   + $signed({nxt.value[SAMPLE_WIDTH-1], nxt.value});
    assign sum_adj = sum + $signed({{SAMPLE_WIDTH{1'b0}}, sum[SAMPLE_WIDTH]});
    assign avg     = sum_adj >>> 1;

    // Select pass, conceal or silence
    always_comb
    begin
        res          = '0;
        res.value    = cur.value;
        res.err      = cur.err;
        if (fix)
        begin
            if (!cur.err)
            begin
                res.is_valid = 1'b1;
            end
            else if (prev.err || nxt.err)
            begin
                res.value  = '0;
                res.is_sil = 1'b1;
            end
            else
            begin
                res.value   = avg[SAMPLE_WIDTH-1:0];
                res.err     = 1'b0;
                res.con     = 1'b1;
                res.is_conc = 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/aec_counter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aec_counter
// Saturating statistics counter with a clipped 32-bit view of its next value.
// ---------------------------------------------------------------------------
module aec_counter
#(
    parameter int COUNT_WIDTH = aec_pkg::COUNT_WIDTH_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic [1:0]                      inc,
    output logic [aec_pkg::TOTAL_WIDTH-1:0] total   // count after this item
);
    import aec_pkg::*;

    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH:0]   sum;

    // Add with carry out; a carry means the ceiling was passed
    assign sum        = {1'b0, count_reg} + (COUNT_WIDTH+1)'(inc);
    assign count_next = !en             ? count_reg :
                        sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Clip or zero-extend to the output field width
    generate
        if (COUNT_WIDTH > TOTAL_WIDTH)
        begin : g_clip
            assign total = (|count_next[COUNT_WIDTH-1:TOTAL_WIDTH]) ?
                           {TOTAL_WIDTH{1'b1}} : count_next[TOTAL_WIDTH-1:0];
        end
        else
        begin : g_ext
            assign total = TOTAL_WIDTH'(count_next);
        end
    endgenerate

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo audio error concealment core.
// ---------------------------------------------------------------------------
// Stereo pairs with error flags and flush items go into the slave stream.
// A local model of the three-tap window predicts every result item, and each
// result taken from the master stream is checked field by field against the
// oldest prediction. A directed part covers the window edges, flushes and
// averaging extremes. Random streams with varying error density follow, with
// random stalls on both sides, and a final stretch runs with no stalls.
// ---------------------------------------------------------------------------
module tb;
    import aec_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 50;

    // Same layout as m_axis_tdata, lowest field last
    typedef struct packed {
        logic [TOTAL_WIDTH-1:0]            silenced_total;
        logic [TOTAL_WIDTH-1:0]            concealed_total;
        logic [TOTAL_WIDTH-1:0]            valid_total;
        logic [1:0]                        con;
        logic [1:0]                        err;
        logic [1:0][SAMPLE_WIDTH-1:0]      smp;
    } pair_result_t;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [S_TDATA_WIDTH-1:0] s_axis_tdata  = '0;
    logic                     s_axis_tuser  = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0] m_axis_tdata;

    // Model of the window and the statistics
    aec_pair_t              win_before;
    aec_pair_t              win_held;
    aec_fill_t              win_fill  = FILL_EMPTY;
    logic [TOTAL_WIDTH-1:0] cnt_valid = '0;
    logic [TOTAL_WIDTH-1:0] cnt_conc  = '0;
    logic [TOTAL_WIDTH-1:0] cnt_sil   = '0;
    pair_result_t           expected_pairs[$];

    bit idle_on         = 1'b1;
    int fail_count      = 0;
    int items_sent      = 0;
    int flushes_sent    = 0;
    int results_checked = 0;
    int idle_cycles     = 0;

    audio_error_concealment_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [TOTAL_WIDTH-1:0] sat_inc(input logic [TOTAL_WIDTH-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Advance the window model by one accepted item; queue a result if one is due
    task automatic predict_concealment(input bit flush, input aec_pair_t incoming);
        pair_result_t res;
        int           sum;
        res = '0;
        if (flush)
        begin
            if (win_fill == FILL_EMPTY)
                return;
            // held pair leaves as it came
            for (int ch = 0; ch < 2; ch++)
            begin
                res.smp[ch] = win_held[ch].value;
                res.err[ch] = win_held[ch].err;
            end
            win_fill = FILL_EMPTY;
        end
        else if (win_fill == FILL_EMPTY)
        begin
            win_held = incoming;
            win_fill = FILL_ONE;
            return;
        end
        else
        begin
            for (int ch = 0; ch < 2; ch++)
            begin
                if (win_fill == FILL_ONE)
                begin
                    // first pair: no left neighbor, pass uncorrected
                    res.smp[ch] = win_held[ch].value;
                    res.err[ch] = win_held[ch].err;
                end
                else if (!win_held[ch].err)
                begin
                    res.smp[ch] = win_held[ch].value;
                    cnt_valid   = sat_inc(cnt_valid);
                end
                else if (win_before[ch].err || incoming[ch].err)
                begin
                    res.err[ch] = 1'b1;
                    cnt_sil     = sat_inc(cnt_sil);
                end
                else
                begin
                    // average of the original neighbors, truncated toward zero
                    sum = int'($signed(win_before[ch].value)) + int'($signed(incoming[ch].value));
                    sum = sum / 2;
                    res.smp[ch] = sum[SAMPLE_WIDTH-1:0];
                    res.con[ch] = 1'b1;
                    cnt_conc    = sat_inc(cnt_conc);
                end
            end
            win_before = win_held;
            win_held   = incoming;
            win_fill   = FILL_FULL;
        end
        res.valid_total     = cnt_valid;
        res.concealed_total = cnt_conc;
        res.silenced_total  = cnt_sil;
        expected_pairs.insert(expected_pairs.size(), res);
    endtask

    // Drive one item at the falling edge and hold it until accepted
    task automatic send_item(input bit flush, input logic [SAMPLE_WIDTH-1:0] l,
                             input logic [SAMPLE_WIDTH-1:0] r, input bit le, input bit re);
        aec_pair_t                p;
        logic [S_TDATA_WIDTH-1:0] word;
        p[CH_LEFT].value  = l;
        p[CH_LEFT].err    = le;
        p[CH_RIGHT].value = r;
        p[CH_RIGHT].err   = re;
        word              = '0;
        word[15:0]        = l;
        word[31:16]       = r;
        word[32]          = le;
        word[33]          = re;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= flush;
        s_axis_tdata  <= word;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
        if (flush)
            flushes_sent++;
        predict_concealment(flush, p);
    endtask

    function automatic logic [SAMPLE_WIDTH-1:0] rand_sample();
        case ($urandom_range(0, 11))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hffff;
            4:       return 16'($urandom_range(0, 7)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_item(input int err_pct);
        bit flush;
        flush = ($urandom_range(0, 99) < 3);
        send_item(flush, rand_sample(), rand_sample(),
                  $urandom_range(0, 99) < err_pct, $urandom_range(0, 99) < err_pct);
    endtask

    task automatic report_mismatch(input string what, input logic [TOTAL_WIDTH-1:0] got,
                                   input logic [TOTAL_WIDTH-1:0] want);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("MISMATCH at result %0d, %s: got %h, want %h",
                     results_checked, what, got, want);
    endtask

    // Window edges, flushes and averaging extremes
    task automatic test_window_edges();
        send_item(1'b1, 16'h5a5a, 16'ha5a5, 1'b1, 1'b1);  // flush with empty window
        send_item(1'b0, 16'h7fff, 16'h8000, 1'b0, 1'b0);  // first pair, stored
        send_item(1'b0, 16'h1234, 16'h4321, 1'b1, 1'b1);  // emits first pair plain
        send_item(1'b0, 16'h7fff, 16'h8001, 1'b0, 1'b0);  // conceal at both extremes
        send_item(1'b0, 16'hffff, 16'h0001, 1'b0, 1'b0);
        send_item(1'b0, 16'hbeef, 16'hcafe, 1'b1, 1'b1);
        send_item(1'b0, 16'h0000, 16'hfffe, 1'b0, 1'b0);  // -0.5 truncates to zero
        send_item(1'b0, 16'h0007, 16'h0009, 1'b1, 1'b0);
        send_item(1'b0, 16'h0008, 16'h0003, 1'b1, 1'b1);  // flagged run: silenced
        send_item(1'b0, 16'hfffd, 16'hffff, 1'b0, 1'b1);
        send_item(1'b0, 16'hffff, 16'h0000, 1'b1, 1'b0);
        send_item(1'b1, 16'hffff, 16'hffff, 1'b0, 1'b0);  // flush, full window
        send_item(1'b1, 16'h0000, 16'h0000, 1'b1, 1'b0);  // flush again, empty
        send_item(1'b0, 16'h0064, 16'hff9c, 1'b1, 1'b1);
        send_item(1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0);  // flush, one pair held
        send_item(1'b0, 16'h0001, 16'h0002, 1'b0, 1'b0);
        send_item(1'b0, 16'h0003, 16'h0004, 1'b1, 1'b0);
        send_item(1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0);  // flagged pair leaves uncorrected
        send_item(1'b0, 16'h8000, 16'h8000, 1'b0, 1'b0);
        send_item(1'b0, 16'h0005, 16'h0005, 1'b1, 1'b1);
        send_item(1'b0, 16'h8000, 16'h8000, 1'b0, 1'b0);  // average of two minimums
        send_item(1'b0, 16'h7fff, 16'h7fff, 1'b1, 1'b1);
        send_item(1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1);  // flagged next neighbor
        send_item(1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0);
    endtask

    // Random pairs; error density is drawn anew every 50 items
    task automatic test_random_stream(input int n_items);
        int err_pct;
        err_pct = 0;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 50 == 0)
            begin
                case ($urandom_range(0, 4))
                    0:       err_pct = 0;
                    1:       err_pct = 5;
                    2:       err_pct = 20;
                    3:       err_pct = 50;
                    default: err_pct = 90;
                endcase
            end
            send_random_item(err_pct);
        end
    endtask

    // Back-to-back items; no new idles or stalls are started on either side
    task automatic test_steady_stream(input int n_items);
        idle_on = 1'b0;
        for (int i = 0; i < n_items; i++)
            send_random_item(i < n_items / 2 ? 15 : 40);
    endtask

    // Result side: random stall bursts while idling is on
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 6) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : result_check
        pair_result_t got;
        pair_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = pair_result_t'(m_axis_tdata[M_FIELD_BITS-1:0]);
            if (m_axis_tdata[M_TDATA_WIDTH-1:M_FIELD_BITS] !== '0)
                report_mismatch("padding bits", 32'(m_axis_tdata[M_TDATA_WIDTH-1:M_FIELD_BITS]), '0);
            if (expected_pairs.size() == 0)
                report_mismatch("unexpected result", 32'(got.smp), '0);
            else
            begin
                want = expected_pairs[0];
                expected_pairs.delete(0);
                for (int ch = 0; ch < 2; ch++)
                begin
                    if (got.smp[ch] !== want.smp[ch])
                        report_mismatch(ch == CH_LEFT ? "out_left" : "out_right",
                                        32'(got.smp[ch]), 32'(want.smp[ch]));
                    if (got.err[ch] !== want.err[ch])
                        report_mismatch(ch == CH_LEFT ? "out_left_error" : "out_right_error",
                                        32'(got.err[ch]), 32'(want.err[ch]));
                    if (got.con[ch] !== want.con[ch])
                        report_mismatch(ch == CH_LEFT ? "out_left_concealed"
                                                      : "out_right_concealed",
                                        32'(got.con[ch]), 32'(want.con[ch]));
                end
                if (got.valid_total !== want.valid_total)
                    report_mismatch("valid_total", got.valid_total, want.valid_total);
                if (got.concealed_total !== want.concealed_total)
                    report_mismatch("concealed_total", got.concealed_total,
                                    want.concealed_total);
                if (got.silenced_total !== want.silenced_total)
                    report_mismatch("silenced_total", got.silenced_total, want.silenced_total);
            end
            results_checked++;
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        test_window_edges();
        test_random_stream(900);
        test_steady_stream(250);
        // drain the result side, then allow the output register to settle
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("sent %0d items (%0d flushes), checked %0d results", items_sent,
                 flushes_sent, results_checked);
        $display("samples passed %0d, concealed %0d, silenced %0d", cnt_valid, cnt_conc,
                 cnt_sil);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
